### src/ssrf_pkg.sv
// Shared constants, codes and types of the SPI register file slave.
package ssrf_pkg;

  localparam int unsigned NUM_DEVICES   = 4;
  localparam int unsigned REGS_PER_DEV  = 256;
  localparam int unsigned MEM_DEPTH     = NUM_DEVICES * REGS_PER_DEV;
  localparam int unsigned MEM_ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned DEV_W         = 4;
  localparam int unsigned BYTE_W        = 8;

  localparam int unsigned CMD_READ_BIT  = 7;
  localparam logic [BYTE_W-1:0] RX_NO_DEV = 8'hff;

  typedef enum logic [1:0] {
    KIND_SPI  = 2'd0,
    KIND_WR   = 2'd1,
    KIND_RD   = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  // Memory access issued by the decode stage.
  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [MEM_ADDR_W-1:0] addr;
    logic [BYTE_W-1:0]     wdata;
  } mem_req_t;

  // Result fields carried alongside a pending memory read.
  typedef struct packed {
    logic              use_mem;
    logic [BYTE_W-1:0] rx;
    logic              status;
  } res_t;

endpackage

### src/spi_register_file_slave.sv
// Top level of the multi-device SPI register file slave.
// Path: an accepted transfer waits in stage 1 for its RAM read data, then moves
// to the output register once that register is empty or not stalled.
// Throughput: one transfer per cycle while input stall is low; each needs at most one access to the register RAM.
// Reset: transfer state clears at once; a sweep then writes zero into all
// NUM_DEVICES*256 RAM entries, with input stall held high.
module spi_register_file_slave (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ssrf_pkg::kind_e              kind_i,
  input  logic [ssrf_pkg::DEV_W-1:0]   device_i,
  input  logic                         first_byte_i,
  input  logic [ssrf_pkg::BYTE_W-1:0]  tx_byte_i,
  input  logic [ssrf_pkg::BYTE_W-1:0]  reg_addr_i,
  input  logic [ssrf_pkg::BYTE_W-1:0]  value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ssrf_pkg::BYTE_W-1:0]  rx_byte_o,
  output logic                         status_o
);
  import ssrf_pkg::*;

  logic              busy;
  logic              accept;
  mem_req_t          mem_req;
  res_t              res;
  logic [BYTE_W-1:0] rdata;

  // Stage 1: waits for RAM read data. Output register behind it lets a new
  // transfer enter while a finished result is still held on the output.
  logic              s1_valid_q, s1_valid_d;
  res_t              s1_res_q;
  logic              s1_move;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] rx_q;
  logic              status_q;

  // Stall input during the clearing sweep, or when both result slots are full and output is stalled.
  // While stage 1 holds, no read is issued, so the RAM read data holds too.
  assign in_stall_o = busy | (s1_valid_q & out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;

  ssrf_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .kind_i       (kind_i),
    .device_i     (device_i),
    .first_byte_i (first_byte_i),
    .tx_byte_i    (tx_byte_i),
    .reg_addr_i   (reg_addr_i),
    .value_i      (value_i),
    .busy_o       (busy),
    .mem_req_o    (mem_req),
    .res_o        (res)
  );

  // Writes land at the accept edge and reads sample at it, so a read of the
  // next transfer always sees the previous write: no forwarding needed.
  ssrf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.addr),
    .rdata_o (rdata)
  );

  assign s1_move     = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign s1_valid_d  = accept | (s1_valid_q & ~s1_move);
  assign out_valid_d = s1_move | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load stage 1 on accept, output on advance.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
    end
    if (s1_move) begin
      rx_q     <= s1_res_q.use_mem ? rdata : s1_res_q.rx;
      status_q <= s1_res_q.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rx_byte_o   = rx_q;
  assign status_o    = status_q;

  a_s1_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("stage 1 result did not advance to empty output");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |-> !accept)
    else $error("transfer accepted over held stage 1 result");

  a_missing_dev_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q) |-> (rx_q == '0 || rx_q == RX_NO_DEV))
    else $error("missing device returned register data");

endmodule

### src/ssrf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ssrf_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data when no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/ssrf_decode.sv
// Item decode, transfer state, memory request and post-reset clearing sweep.
module ssrf_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  ssrf_pkg::kind_e               kind_i,
  input  logic [ssrf_pkg::DEV_W-1:0]    device_i,
  input  logic                          first_byte_i,
  input  logic [ssrf_pkg::BYTE_W-1:0]   tx_byte_i,
  input  logic [ssrf_pkg::BYTE_W-1:0]   reg_addr_i,
  input  logic [ssrf_pkg::BYTE_W-1:0]   value_i,
  output logic                          busy_o,
  output ssrf_pkg::mem_req_t            mem_req_o,
  output ssrf_pkg::res_t                res_o
);
  import ssrf_pkg::*;

  logic                  clearing_q, clearing_d;
  logic [MEM_ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic                  cmd_seen_q, cmd_seen_d;
  logic                  read_mode_q, read_mode_d;
  logic [BYTE_W-1:0]     ptr_q, ptr_d;

  logic                  present;
  logic [MEM_ADDR_W-1:0] ptr_addr;
  logic [MEM_ADDR_W-1:0] bd_addr;
  mem_req_t              req;

  assign present  = {1'b0, device_i} < (DEV_W+1)'(NUM_DEVICES);
  assign ptr_addr = MEM_ADDR_W'({device_i, ptr_q});
  assign bd_addr  = MEM_ADDR_W'({device_i, reg_addr_i});

  always_comb begin
    cmd_seen_d  = cmd_seen_q;
    read_mode_d = read_mode_q;
    ptr_d       = ptr_q;
    req.we      = 1'b0;
    req.re      = 1'b0;
    req.addr    = ptr_addr;
    req.wdata   = tx_byte_i;
    res_o.use_mem = 1'b0;
    res_o.rx      = '0;
    res_o.status  = ~present;

    case (kind_i)
      KIND_SPI: begin
        if (present) begin
          if (first_byte_i || !cmd_seen_q) begin
            cmd_seen_d  = 1'b1;
            read_mode_d = tx_byte_i[CMD_READ_BIT];
            ptr_d       = {1'b0, tx_byte_i[CMD_READ_BIT-1:0]};
          end else begin
            req.re        = read_mode_q;
            req.we        = ~read_mode_q;
            res_o.use_mem = read_mode_q;
            ptr_d         = ptr_q + 8'd1;
          end
        end
      end
      KIND_WR: begin
        req.addr  = bd_addr;
        req.wdata = value_i;
        req.we    = present;
      end
      KIND_RD: begin
        req.addr      = bd_addr;
        req.re        = present;
        res_o.use_mem = present;
        if (!present) begin
          res_o.rx = RX_NO_DEV;
        end
      end
      default: begin
        res_o.status = 1'b0;
      end
    endcase
  end

  // sweep zeros through the memory after reset
  always_comb begin
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + MEM_ADDR_W'(1);
      if (clr_addr_q == MEM_ADDR_W'(MEM_DEPTH - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_comb begin
    if (clearing_q) begin
      mem_req_o.we    = 1'b1;
      mem_req_o.re    = 1'b0;
      mem_req_o.addr  = clr_addr_q;
      mem_req_o.wdata = '0;
    end else begin
      mem_req_o.we    = req.we & accept_i;
      mem_req_o.re    = req.re & accept_i;
      mem_req_o.addr  = req.addr;
      mem_req_o.wdata = req.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_addr_q  <= '0;
      cmd_seen_q  <= 1'b0;
      read_mode_q <= 1'b0;
      ptr_q       <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
      if (accept_i) begin
        cmd_seen_q  <= cmd_seen_d;
        read_mode_q <= read_mode_d;
        ptr_q       <= ptr_d;
      end
    end
  end

  assign busy_o = clearing_q;

  a_rw_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req_o.we && mem_req_o.re))
    else $error("memory read and write issued together");

  a_sweep_ends_at_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_q) |-> $past(clr_addr_q) == MEM_ADDR_W'(MEM_DEPTH - 1))
    else $error("clearing sweep ended early");

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !accept_i)
    else $error("transfer accepted during clearing sweep");

endmodule
